@@ rtl/core/lprt_pkg.sv @@
// ----------------------------------------------------------------------------
// lprt_pkg
// Shared types, constants and the arctangent table of the lidar point
// ring and time tagger.
// ----------------------------------------------------------------------------
package lprt_pkg;

    // limits
    localparam int MAX_RINGS      = 1024;
    localparam int MAX_POINTS     = 1048576;
    localparam int RING_RST       = 128;

    // field of view half width, Q16 radians; the full span 2*FOV_HALF is
    // 16 * 3217, divided by a shift and a multiply by ceil(2^36 / 3217)
    localparam int FOV_HALF       = 25736;
    localparam int RING_PRESH     = 4;
    localparam int RING_RECIP     = 21361355;
    localparam int RING_RSH       = 36;

    // pipeline geometry
    localparam int SQRT_STEPS     = 32;
    localparam int CORDIC_STEPS   = 16;
    localparam int TF_BITS        = 16;
    localparam int ST_TF0         = 1;
    localparam int ST_TFLD        = ST_TF0 + TF_BITS;
    localparam int ST_SQRT0       = 2;
    localparam int ST_CORD0       = ST_SQRT0 + SQRT_STEPS;
    localparam int ST_MUL         = ST_CORD0 + CORDIC_STEPS;
    localparam int ST_RQ          = ST_MUL + 1;
    localparam int ST_OUT         = ST_RQ + 1;
    localparam int NSTG           = ST_OUT + 1;

    // integer square root lane
    typedef struct packed {
        logic [63:0] v;
        logic [63:0] res;
    } t_sqr;

    // CORDIC vectoring lane
    typedef struct packed {
        logic signed [51:0] x;
        logic signed [51:0] y;
        logic signed [17:0] a;
        logic               org;
    } t_cord;

    // restoring divider lane
    typedef struct packed {
        logic [36:0] rem;
        logic [20:0] dvs;
        logic [15:0] q;
    } t_div;

    // fields that travel alongside the lanes
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [15:0] inten;
        logic [10:0] n;
        logic        sat;
        logic [15:0] tf;
        logic        neg;
    } t_pass;

    // round(atan(2^-i) * 65536)
    function automatic logic signed [17:0] atan_q16(input logic [3:0] i);
        logic signed [17:0] t;
        unique case (i)
            4'd0:    t = 18'sd51472;
            4'd1:    t = 18'sd30386;
            4'd2:    t = 18'sd16055;
            4'd3:    t = 18'sd8150;
            4'd4:    t = 18'sd4091;
            4'd5:    t = 18'sd2047;
            4'd6:    t = 18'sd1024;
            4'd7:    t = 18'sd512;
            4'd8:    t = 18'sd256;
            4'd9:    t = 18'sd128;
            4'd10:   t = 18'sd64;
            4'd11:   t = 18'sd32;
            4'd12:   t = 18'sd16;
            4'd13:   t = 18'sd8;
            4'd14:   t = 18'sd4;
            default: t = 18'sd2;
        endcase
        return t;
    endfunction

endpackage

@@ rtl/core/lprt_in_if.sv @@
// ----------------------------------------------------------------------------
// lprt_in_if
// Point request channel: valid/ready with the raw point fields.
// ----------------------------------------------------------------------------
interface lprt_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] coord_z;
    logic [15:0] intensity_in;
    logic [19:0] point_index;
    logic [20:0] point_count;

    modport source (output valid, coord_x, coord_y, coord_z, intensity_in,
                    point_index, point_count, input ready);
    modport sink   (input valid, coord_x, coord_y, coord_z, intensity_in,
                    point_index, point_count, output ready);
endinterface

@@ rtl/core/lprt_out_if.sv @@
// ----------------------------------------------------------------------------
// lprt_out_if
// Tagged point channel: valid/ready with the tagged point fields.
// ----------------------------------------------------------------------------
interface lprt_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [15:0] intensity_out;
    logic [9:0]  ring;
    logic [15:0] time_fraction;

    modport source (output valid, out_x, out_y, out_z, intensity_out, ring,
                    time_fraction, input ready);
    modport sink   (input valid, out_x, out_y, out_z, intensity_out, ring,
                    time_fraction, output ready);
endinterface

@@ rtl/core/lprt_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// lprt_sqrt_cell
// One step of the bit-pair integer square root, registered.
// ----------------------------------------------------------------------------
module lprt_sqrt_cell (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [4:0]           i_k,
    input  lprt_pkg::t_sqr       i_d,
    output lprt_pkg::t_sqr       o_d
);
    logic [63:0]    w_bit;
    logic [63:0]    w_trial;
    lprt_pkg::t_sqr n_d;
    lprt_pkg::t_sqr r_d;

    // trial bit is 4^(31-k)
    assign w_bit   = 64'h4000_0000_0000_0000 >> {i_k, 1'b0};
    assign w_trial = i_d.res + w_bit;

    always_comb begin
        if (i_d.v >= w_trial) begin
            n_d.v   = i_d.v - w_trial;
            n_d.res = (i_d.res >> 1) + w_bit;
        end else begin
            n_d.v   = i_d.v;
            n_d.res = i_d.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

@@ rtl/core/lprt_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// lprt_cordic_cell
// One CORDIC vectoring rotation, registered.
// ----------------------------------------------------------------------------
module lprt_cordic_cell (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [3:0]           i_step,
    input  lprt_pkg::t_cord      i_d,
    output lprt_pkg::t_cord      o_d
);
    logic signed [51:0] w_dx;
    logic signed [51:0] w_dy;
    logic signed [17:0] w_t;
    lprt_pkg::t_cord    n_d;
    lprt_pkg::t_cord    r_d;

    assign w_dx = i_d.y >>> i_step;
    assign w_dy = i_d.x >>> i_step;
    assign w_t  = lprt_pkg::atan_q16(i_step);

    // rotate toward y = 0, both updates from the old x and y
    always_comb begin
        n_d.org = i_d.org;
        if (!i_d.y[51]) begin
            n_d.x = i_d.x + w_dx;
            n_d.y = i_d.y - w_dy;
            n_d.a = i_d.a + w_t;
        end else begin
            n_d.x = i_d.x - w_dx;
            n_d.y = i_d.y + w_dy;
            n_d.a = i_d.a - w_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

@@ rtl/core/lprt_div_cell.sv @@
// ----------------------------------------------------------------------------
// lprt_div_cell
// One quotient bit of a restoring division, registered.
// ----------------------------------------------------------------------------
module lprt_div_cell (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [3:0]           i_sh,
    input  lprt_pkg::t_div       i_d,
    output lprt_pkg::t_div       o_d
);
    logic [36:0]    w_dvs;
    lprt_pkg::t_div n_d;
    lprt_pkg::t_div r_d;

    assign w_dvs = 37'(i_d.dvs) << i_sh;

    always_comb begin
        n_d.dvs = i_d.dvs;
        if (i_d.rem >= w_dvs) begin
            n_d.rem = i_d.rem - w_dvs;
            n_d.q   = {i_d.q[14:0], 1'b1};
        end else begin
            n_d.rem = i_d.rem;
            n_d.q   = {i_d.q[14:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

@@ rtl/core/lidar_point_ring_and_time_tagger.sv @@
// ----------------------------------------------------------------------------
// lidar_point_ring_and_time_tagger
// Tags each lidar point with a ring number and a normalized time.
// ----------------------------------------------------------------------------
// Usage:
//   i_pt carries one point per request (x, y, z in Q16.16, intensity, index
//   and cloud point count). o_pt returns the same point with its ring number
//   from the elevation angle and time_fraction = index/count in Q0.16.
//   The ring count register is written through i_cfg_we / i_cfg_wdata while
//   no request is in flight.
// Throughput and depth:
//   One request per cycle is taken while o_pt does not stall: a chain of
//   53 register stages (squares, their sum, 32 square root steps, 16 CORDIC
//   rotations, ring multiply and quotient, clamp; the 16 time divider steps
//   run alongside) holds up to 53 points.
// Stall:
//   The whole chain advances while the output stage is empty or taken; when
//   o_pt stalls with a result held, i_pt.ready drops and every cell holds.
// Reset:
//   Synchronous, active low. Clears all valid bits and sets the ring count
//   to 128. No result is lost or repeated across stalls.
// ----------------------------------------------------------------------------
module lidar_point_ring_and_time_tagger (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [10:0]  i_cfg_wdata,
    lprt_in_if.sink      i_pt,
    lprt_out_if.source   o_pt
);
    logic                          w_en;
    logic [lprt_pkg::NSTG-1:0]     r_vld;
    logic [10:0]                   r_ring_count;

    lprt_pkg::t_pass               r_pass [lprt_pkg::NSTG];
    lprt_pkg::t_pass               n_pass [lprt_pkg::NSTG];

    logic [63:0]                   r_sx;
    logic [63:0]                   r_sy;
    lprt_pkg::t_sqr                r_sqr0;
    lprt_pkg::t_sqr                w_sqr  [lprt_pkg::SQRT_STEPS+1];
    lprt_pkg::t_cord               w_cord [lprt_pkg::CORDIC_STEPS+1];
    lprt_pkg::t_div                r_tf0;
    lprt_pkg::t_div                w_tf   [lprt_pkg::TF_BITS+1];

    logic [31:0]                   w_ax;
    logic [31:0]                   w_ay;
    logic [20:0]                   w_cnt;
    logic [10:0]                   w_n;
    logic [31:0]                   w_r;
    logic signed [17:0]            w_elev;
    logic signed [18:0]            w_t;
    logic [27:0]                   r_num;
    logic [23:0]                   w_num_hi;
    logic [48:0]                   w_rprod;
    logic [11:0]                   r_rq;
    logic [11:0]                   w_nm1;
    logic [9:0]                    r_ring;
    logic [9:0]                    n_ring;

    // the chain moves when the output stage is free
    assign w_en      = !r_vld[lprt_pkg::NSTG-1] || o_pt.ready;
    assign i_pt.ready = w_en;

    // control: valid chain and ring count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= '0;
            r_ring_count <= 11'(lprt_pkg::RING_RST);
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[lprt_pkg::NSTG-2:0], i_pt.valid};
            end
            if (i_cfg_we) begin
                r_ring_count <= i_cfg_wdata;
            end
        end
    end

    // front cell: magnitudes, clamps, squares
    assign w_ax  = i_pt.coord_x[31] ? 32'(-i_pt.coord_x) : i_pt.coord_x;
    assign w_ay  = i_pt.coord_y[31] ? 32'(-i_pt.coord_y) : i_pt.coord_y;
    assign w_cnt = (i_pt.point_count > 21'(lprt_pkg::MAX_POINTS))
                   ? 21'(lprt_pkg::MAX_POINTS) : i_pt.point_count;
    assign w_n   = (r_ring_count == 11'd0) ? 11'd1
                 : (r_ring_count > 11'(lprt_pkg::MAX_RINGS))
                   ? 11'(lprt_pkg::MAX_RINGS) : r_ring_count;

    always_comb begin
        n_pass[0].x     = i_pt.coord_x;
        n_pass[0].y     = i_pt.coord_y;
        n_pass[0].z     = i_pt.coord_z;
        n_pass[0].inten = i_pt.intensity_in;
        n_pass[0].n     = w_n;
        n_pass[0].sat   = (21'(i_pt.point_index) >= w_cnt);
        n_pass[0].tf    = '0;
        n_pass[0].neg   = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pass[0]  <= n_pass[0];
            r_sx       <= w_ax * w_ax;
            r_sy       <= w_ay * w_ay;
            r_tf0.rem  <= {1'b0, i_pt.point_index, 16'h0};
            r_tf0.dvs  <= w_cnt;
            r_tf0.q    <= '0;
        end
    end

    // sum of squares feeds the root chain
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sqr0.v   <= r_sx + r_sy;
            r_sqr0.res <= '0;
        end
    end

    // side fields ride along; time and sign are loaded where they are known
    for (genvar s = 1; s < lprt_pkg::NSTG; s++) begin : g_pass
        always_comb begin
            n_pass[s] = r_pass[s-1];
            if (s == lprt_pkg::ST_TFLD) begin
                n_pass[s].tf = r_pass[s-1].sat ? 16'hFFFF
                                               : w_tf[lprt_pkg::TF_BITS].q;
            end
            if (s == lprt_pkg::ST_MUL) begin
                n_pass[s].neg = w_t[18];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_pass[s] <= n_pass[s];
            end
        end
    end

    // time fraction: 16 divider cells
    assign w_tf[0] = r_tf0;
    for (genvar g = 0; g < lprt_pkg::TF_BITS; g++) begin : g_tf
        lprt_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_sh  (4'(lprt_pkg::TF_BITS - 1 - g)),
            .i_d   (w_tf[g]),
            .o_d   (w_tf[g+1])
        );
    end

    // horizontal range: 32 square root cells
    assign w_sqr[0] = r_sqr0;
    for (genvar g = 0; g < lprt_pkg::SQRT_STEPS; g++) begin : g_sqrt
        lprt_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_k   (5'(g)),
            .i_d   (w_sqr[g]),
            .o_d   (w_sqr[g+1])
        );
    end

    // elevation: 16 CORDIC cells
    assign w_r = w_sqr[lprt_pkg::SQRT_STEPS].res[31:0];
    always_comb begin
        w_cord[0].x   = {4'h0, w_r, 16'h0};
        w_cord[0].y   = {{4{r_pass[lprt_pkg::ST_CORD0-1].z[31]}},
                         r_pass[lprt_pkg::ST_CORD0-1].z, 16'h0};
        w_cord[0].a   = '0;
        w_cord[0].org = (w_r == 32'd0) && (r_pass[lprt_pkg::ST_CORD0-1].z == 32'd0);
    end
    for (genvar g = 0; g < lprt_pkg::CORDIC_STEPS; g++) begin : g_cord
        lprt_cordic_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_step (4'(g)),
            .i_d    (w_cord[g]),
            .o_d    (w_cord[g+1])
        );
    end

    // ring numerator: (elevation + half view) * rings
    assign w_elev = w_cord[lprt_pkg::CORDIC_STEPS].org ? 18'sd0
                                                       : w_cord[lprt_pkg::CORDIC_STEPS].a;
    assign w_t    = 19'(w_elev) + 19'(lprt_pkg::FOV_HALF);
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num <= 28'(w_t[17:0] * r_pass[lprt_pkg::ST_MUL-1].n);
        end
    end

    // ring quotient: drop the power-of-two part of the span, then multiply
    // by the rounded-up reciprocal of the odd part; exact below 2^24
    assign w_num_hi = r_num[27:lprt_pkg::RING_PRESH];
    assign w_rprod  = 49'(w_num_hi) * 49'(lprt_pkg::RING_RECIP);
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rq <= w_rprod[lprt_pkg::RING_RSH+11:lprt_pkg::RING_RSH];
        end
    end

    // output stage: clamp the ring
    assign w_nm1 = 12'(r_pass[lprt_pkg::ST_OUT-1].n) - 12'd1;
    always_comb begin
        if (r_pass[lprt_pkg::ST_OUT-1].neg) begin
            n_ring = '0;
        end else if (r_rq > w_nm1) begin
            n_ring = w_nm1[9:0];
        end else begin
            n_ring = r_rq[9:0];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ring <= n_ring;
        end
    end

    assign o_pt.valid         = r_vld[lprt_pkg::NSTG-1];
    assign o_pt.out_x         = r_pass[lprt_pkg::NSTG-1].x;
    assign o_pt.out_y         = r_pass[lprt_pkg::NSTG-1].y;
    assign o_pt.out_z         = r_pass[lprt_pkg::NSTG-1].z;
    assign o_pt.intensity_out = r_pass[lprt_pkg::NSTG-1].inten;
    assign o_pt.ring          = r_ring;
    assign o_pt.time_fraction = r_pass[lprt_pkg::NSTG-1].tf;

    // ring never exceeds the effective ring count
    a_ring_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pt.valid |-> (11'(o_pt.ring) < r_pass[lprt_pkg::NSTG-1].n))
        else $error("ring beyond ring count");

    // effective ring count stays within 1..MAX_RINGS
    a_n_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_pass[0].n != 11'd0 &&
                      r_pass[0].n <= 11'(lprt_pkg::MAX_RINGS)))
        else $error("effective ring count out of range");

    // a held result keeps the chain frozen
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pt.valid && !o_pt.ready |=> $stable(r_vld) && o_pt.valid)
        else $error("chain moved during stall");

endmodule

@@ bench/lidar_point_ring_and_time_tagger_test.sv @@
// ----------------------------------------------------------------------------
// lidar_point_ring_and_time_tagger_test
// Self-checking bench: drives points through the valid/ready channels, runs
// several ring count settings, predicts ring and time fraction in-bench and
// compares every tagged point in order.
// ----------------------------------------------------------------------------
module lidar_point_ring_and_time_tagger_test;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [15:0] inten;
        logic [19:0] idx;
        logic [20:0] cnt;
    } t_point;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [15:0] inten;
        logic [9:0]  ring;
        logic [15:0] tf;
    } t_tagged;

    // directed row: point, whether the result is typed in, and that result
    typedef struct packed {
        t_point  pt;
        logic    known;
        logic [9:0]  ring;
        logic [15:0] tf;
    } t_row;

    localparam int WATCH_LIMIT = 20000;
    localparam int N_RANDOM    = 600;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [10:0] i_cfg_wdata = '0;

    lprt_in_if  pt_in();
    lprt_out_if pt_out();

    lidar_point_ring_and_time_tagger u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pt        (pt_in),
        .o_pt        (pt_out)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_tagged     tagged_q[$];
    logic [10:0] ring_reg;
    int          err_count = 0;
    int          send_idle = 0;
    int          recv_idle = 0;
    int          hold_len = 0;
    int          n_sent = 0;
    int          n_recv = 0;
    int          quiet = 0;

    initial begin
        pt_in.valid = 1'b0;
        pt_in.coord_x = '0;
        pt_in.coord_y = '0;
        pt_in.coord_z = '0;
        pt_in.intensity_in = '0;
        pt_in.point_index = '0;
        pt_in.point_count = 21'd1;
        pt_out.ready = 1'b0;
    end

    // floor square root of a 64-bit value
    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'h1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // predicted tagged point for the current ring count
    function automatic t_tagged tag_point(input t_point p);
        t_tagged t;
        longint sx, sy, sz, cx, cy, dx, dy, acc, n, num, rg;
        logic [63:0] ax, ay, r, q;
        longint tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2};
        logic [20:0] c;
        sx = longint'($signed(p.x));
        sy = longint'($signed(p.y));
        sz = longint'($signed(p.z));
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        r = root_floor(ax * ax + ay * ay);
        acc = 0;
        if (!(r == 0 && sz == 0)) begin
            cx = longint'(r) * 65536;
            cy = sz * 65536;
            for (int i = 0; i < 16; i++) begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (cy >= 0) begin
                    cx += dx; cy -= dy; acc += tab[i];
                end else begin
                    cx -= dx; cy += dy; acc -= tab[i];
                end
            end
        end
        n = ring_reg;
        if (n < 1) n = 1;
        if (n > lprt_pkg::MAX_RINGS) n = lprt_pkg::MAX_RINGS;
        num = (acc + lprt_pkg::FOV_HALF) * n;
        rg = (num < 0) ? 0 : num / (2 * lprt_pkg::FOV_HALF);
        if (rg > n - 1) rg = n - 1;
        c = p.cnt;
        if (c > 21'(lprt_pkg::MAX_POINTS)) c = 21'(lprt_pkg::MAX_POINTS);
        if (c == 0) q = 65535;
        else begin
            q = (64'(p.idx) << 16) / c;
            if (q > 65535) q = 65535;
        end
        t.x = p.x; t.y = p.y; t.z = p.z; t.inten = p.inten;
        t.ring = rg[9:0];
        t.tf = q[15:0];
        return t;
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        err_count++;
        $display("mismatch %s at result %0d: got %0h want %0h", what, n_recv, got, want);
    endtask

    // receiver: ready with random stalls, forced hold-off when asked
    always @(posedge i_clk) begin
        if (hold_len > 0) hold_len <= hold_len - 1;
        if (hold_len > 1) pt_out.ready <= 1'b0;
        else pt_out.ready <= ($urandom_range(99) >= recv_idle);
    end

    // checker
    always @(posedge i_clk) begin
        t_tagged w;
        if (i_rst_n && pt_out.valid && pt_out.ready) begin
            n_recv++;
            if (tagged_q.size() == 0) begin
                report_mismatch("unexpected result", pt_out.out_x, 0);
            end else begin
                w = tagged_q.pop_front();
                if (pt_out.out_x !== w.x) report_mismatch("out_x", pt_out.out_x, w.x);
                if (pt_out.out_y !== w.y) report_mismatch("out_y", pt_out.out_y, w.y);
                if (pt_out.out_z !== w.z) report_mismatch("out_z", pt_out.out_z, w.z);
                if (pt_out.intensity_out !== w.inten)
                    report_mismatch("intensity", pt_out.intensity_out, w.inten);
                if (pt_out.ring !== w.ring) report_mismatch("ring", pt_out.ring, w.ring);
                if (pt_out.time_fraction !== w.tf)
                    report_mismatch("time_fraction", pt_out.time_fraction, w.tf);
            end
        end
    end

    // watchdog on cycles with no request moving on either side
    always @(posedge i_clk) begin
        if ((pt_in.valid && pt_in.ready) || (pt_out.valid && pt_out.ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WATCH_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCH_LIMIT);
            $display("lidar_point_ring_and_time_tagger regression: fail");
            $finish;
        end
    end

    // offer one point, hold until accepted; expectation queued at acceptance
    task automatic send_point(input t_point p, input bit known,
                              input logic [9:0] kr, input logic [15:0] kt);
        t_tagged t;
        while ($urandom_range(99) < send_idle) begin
            pt_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_in.valid <= 1'b1;
        pt_in.coord_x <= p.x;
        pt_in.coord_y <= p.y;
        pt_in.coord_z <= p.z;
        pt_in.intensity_in <= p.inten;
        pt_in.point_index <= p.idx;
        pt_in.point_count <= p.cnt;
        @(posedge i_clk);
        while (!pt_in.ready) @(posedge i_clk);
        t = tag_point(p);
        if (known) begin
            t.ring = kr;
            t.tf = kt;
        end
        tagged_q = {tagged_q, t};
        n_sent++;
    endtask

    task automatic drain();
        pt_in.valid <= 1'b0;
        while (tagged_q.size() != 0) @(posedge i_clk);
        repeat (70) @(posedge i_clk);
    endtask

    task automatic write_rings(input logic [10:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        ring_reg = v;
    endtask

    // coordinate mix: small points, wide points with a small z, and fully random points
    function automatic t_point rand_point();
        t_point p;
        int k;
        k = $urandom_range(3);
        p.x = $urandom; p.y = $urandom; p.z = $urandom;
        if (k == 0) begin
            p.x = $signed($urandom_range(2000000)) - 1000000;
            p.y = $signed($urandom_range(2000000)) - 1000000;
            p.z = $signed($urandom_range(600000)) - 300000;
        end else if (k == 1) begin
            p.z = $signed($urandom_range(400000)) - 200000;
            p.x = $signed($urandom_range(4000000)) - 2000000;
        end
        p.inten = $urandom;
        p.cnt = ($urandom_range(9) == 0) ? 21'($urandom) : 21'($urandom_range(1, 4096));
        p.idx = ($urandom_range(7) == 0) ? 20'($urandom)
                : 20'($urandom_range(p.cnt == 0 ? 0 : p.cnt - 1));
        return p;
    endfunction

    t_row rows[20];
    logic [10:0] ring_set[5] = '{11'd1, 11'd1024, 11'd2047, 11'd0, 11'd37};

    initial begin
        // point fields: x, y, z, intensity, index, count; known ring / tf
        rows[0]  = '{'{32'h0, 32'h0, 32'h0, 16'h0, 20'h0, 21'h1}, 1, 10'd64, 16'd0};
        rows[1]  = '{'{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'hffff,
                       20'hfffff, 21'h100000}, 0, 0, 0};
        rows[2]  = '{'{32'h80000000, 32'h80000000, 32'h80000000, 16'h0,
                       20'h0, 21'h1fffff}, 0, 0, 0};
        rows[3]  = '{'{32'h0, 32'h0, 32'h10000, 16'h1234, 20'h5, 21'h0}, 1, 10'd127, 16'hffff};
        rows[4]  = '{'{32'h0, 32'h0, 32'hffff0000, 16'h5, 20'h9, 21'h9}, 1, 10'd0, 16'hffff};
        rows[5]  = '{'{32'h10000, 32'h0, 32'h0, 16'h7, 20'h1, 21'h2}, 0, 0, 0};
        rows[6]  = '{'{32'hffff0000, 32'h0, 32'h0, 16'h8, 20'h3, 21'h4}, 0, 0, 0};
        rows[7]  = '{'{32'h0, 32'h10000, 32'h1000, 16'h9, 20'hfffff, 21'h1fffff}, 0, 0, 0};
        rows[8]  = '{'{32'h0, 32'hffff0000, 32'hfffff000, 16'ha, 20'h10, 21'h11}, 0, 0, 0};
        rows[9]  = '{'{32'h30000, 32'h40000, 32'h2000, 16'hb, 20'h0, 21'h100000}, 0, 0, 0};
        rows[10] = '{'{32'h1, 32'h0, 32'h0, 16'hc, 20'h1, 21'h3}, 0, 0, 0};
        rows[11] = '{'{32'h0, 32'h0, 32'h1, 16'hd, 20'hfffff, 21'h100001}, 0, 0, 0};
        rows[12] = '{'{32'h0, 32'h0, 32'hffffffff, 16'he, 20'h7, 21'h7}, 1, 10'd0, 16'hffff};
        rows[13] = '{'{32'h100000, 32'h0, 32'h6a09, 16'hf, 20'h2, 21'h5}, 0, 0, 0};
        rows[14] = '{'{32'h100000, 32'h0, 32'hffff95f7, 16'h10, 20'h2, 21'h5}, 0, 0, 0};
        rows[15] = '{'{32'h5555aaaa, 32'haaaa5555, 32'h0f0f0f0f, 16'haaaa,
                       20'haaaaa, 21'h155555}, 0, 0, 0};
        rows[16] = '{'{32'haaaa5555, 32'h5555aaaa, 32'hf0f0f0f0, 16'h5555,
                       20'h55555, 21'h0aaaaa}, 0, 0, 0};
        rows[17] = '{'{32'h0, 32'h0, 32'h0, 16'hffff, 20'h0, 21'h0}, 1, 10'd64, 16'hffff};
        rows[18] = '{'{32'h20000, 32'h0, 32'h0, 16'h1, 20'h8, 21'h10}, 0, 0, 0};
        rows[19] = '{'{32'h0, 32'h0, 32'h7fffffff, 16'h2, 20'h0, 21'h2}, 1, 10'd127, 16'd0};

        ring_reg = 11'(lprt_pkg::RING_RST);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table at reset ring count
        foreach (rows[i]) send_point(rows[i].pt, rows[i].known, rows[i].ring, rows[i].tf);
        drain();

        // each ring setting, directed table again then random points
        for (int s = 0; s < 5; s++) begin
            write_rings(ring_set[s]);
            foreach (rows[i]) send_point(rows[i].pt, 0, 0, 0);
            for (int k = 0; k < N_RANDOM / 5; k++) begin
                if (k < 50)       begin send_idle = 11; recv_idle = 52; end
                else if (k < 100) begin send_idle = 52; recv_idle = 11; end
                else              begin send_idle = 0;  recv_idle = 0;  end
                // long receiver hold-off so the chain fills and stalls input
                if (k == 40) hold_len = 300;
                // sender pause until everything is back
                if (k == 110) begin
                    pt_in.valid <= 1'b0;
                    while (tagged_q.size() != 0) @(posedge i_clk);
                end
                send_point(rand_point(), 0, 0, 0);
            end
            drain();
        end

        $display("covered %0d points over reset and %0d ring count settings", n_sent, 5);
        $display("checked %0d tagged points, %0d mismatches", n_recv, err_count);
        if (err_count == 0) begin
            $display("lidar_point_ring_and_time_tagger regression: pass");
        end else begin
            $display("lidar_point_ring_and_time_tagger regression: fail");
        end
        $finish;
    end
endmodule
